@@ rtl/icsp_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icsp_pkg
// Types and constants shared by the bit-serial programming master.
// ----------------------------------------------------------------------------
package icsp_pkg;

	localparam int LEN_W   = 7;
	localparam int DLY_W   = 8;
	localparam int CNT_W   = 9;
	localparam int BITS_W  = 64;
	localparam int POS_W   = 6;
	localparam int WORD_W  = 14;

	localparam logic [LEN_W-1:0] MAX_BITS  = 7'd64;
	localparam logic [DLY_W-1:0] MAX_DELAY = 8'd255;

	localparam int IN_DATA_W  = 88;
	localparam int OUT_DATA_W = 24;

	typedef enum logic {
		FUNC_TICK = 1'b0,
		FUNC_LOAD = 1'b1
	} func_t;

	typedef struct packed {
		func_t              func;
		logic               dat_in;
		logic               dir_in;
		logic [LEN_W-1:0]   bit_len;
		logic [DLY_W-1:0]   delay_ticks;
		logic               mclr_level;
		logic [BITS_W-1:0]  send_bits;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0]   bit_count;
		logic               clk_level;
		logic               dat_level;
		logic [BITS_W-1:0]  shift_bits;
		logic               cur_dir_in;
		logic [LEN_W-1:0]   cur_len;
		logic [DLY_W-1:0]   cur_delay;
		logic               cur_mclr;
		logic               busy;
		logic               word_sent;
	} state_t;

	typedef struct packed {
		logic               clk_out;
		logic               dat_out;
		logic               dat_drive;
		logic               mclr_out;
		logic               word_valid;
		logic [WORD_W-1:0]  rx_word;
		logic               idle;
	} out_item_t;

endpackage
`default_nettype wire

@@ rtl/icsp_step.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icsp_step
// Next-state and result logic for one tick or one descriptor load.
// ----------------------------------------------------------------------------
module icsp_step
	import icsp_pkg::*;
(
	input  wire in_item_t  item,
	input  wire state_t    st,
	output state_t         st_nx,
	output out_item_t      res
);

	logic [CNT_W-1:0]  total;
	logic [CNT_W-1:0]  len_ext;
	logic [POS_W-1:0]  pos;
	logic              word_valid;
	logic [WORD_W-1:0] word;

	assign len_ext = {{(CNT_W-LEN_W){1'b0}}, st.cur_len};
	assign total   = len_ext + {{(CNT_W-DLY_W){1'b0}}, st.cur_delay};
	assign pos     = st.bit_count[POS_W-1:0];

	always_comb begin
		st_nx      = st;
		word_valid = 1'b0;
		word       = '0;
		if (item.func == FUNC_LOAD) begin
			if (!st.busy) begin
				st_nx.cur_dir_in = item.dir_in;
				st_nx.cur_len    = (item.bit_len > MAX_BITS) ? MAX_BITS : item.bit_len;
				st_nx.cur_delay  = (item.delay_ticks > MAX_DELAY) ? MAX_DELAY
				                                                   : item.delay_ticks;
				st_nx.cur_mclr   = item.mclr_level;
				st_nx.shift_bits = item.send_bits;
				st_nx.bit_count  = '0;
				st_nx.word_sent  = 1'b0;
				st_nx.busy       = 1'b1;
			end
		end else if (st.busy) begin
			if (st.bit_count < len_ext) begin
				if (st.clk_level) begin
					st_nx.clk_level = 1'b0;
					if (st.cur_dir_in)
						st_nx.shift_bits[pos] = item.dat_in;
					st_nx.bit_count = st.bit_count + 1'b1;
				end else begin
					if (!st.cur_dir_in)
						st_nx.dat_level = st.shift_bits[pos];
					st_nx.clk_level = 1'b1;
				end
			end else if (st.bit_count < total) begin
				st_nx.bit_count = st.bit_count + 1'b1;
			end

			if (st.cur_dir_in && (st_nx.bit_count >= len_ext) && !st.word_sent) begin
				word_valid      = 1'b1;
				word            = st_nx.shift_bits[WORD_W:1];
				st_nx.word_sent = 1'b1;
			end

			if ((st_nx.bit_count >= total) && (!st.cur_dir_in || st_nx.word_sent))
				st_nx.busy = 1'b0;
		end
	end

	always_comb begin
		res.clk_out    = st_nx.clk_level;
		res.dat_out    = st_nx.dat_level;
		res.dat_drive  = !st_nx.cur_dir_in;
		res.mclr_out   = st_nx.cur_mclr;
		res.word_valid = word_valid;
		res.rx_word    = word;
		res.idle       = !st_nx.busy;
	end

endmodule
`default_nettype wire

@@ rtl/icsp_bit_serial_transfer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// icsp_bit_serial_transfer
// Bit-serial programming-interface master driving clock, data and reset pins.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser selects a timing tick (0) or a descriptor load (1).
// A descriptor carries direction, bit count, post-transfer delay, reset-pin
// level and up to 64 bits sent LSB first. Each tick advances the pin sequence
// by one half bit: data is set with the rising clock, reads sample on the fall.
// Descriptors that arrive while a transfer is in progress are dropped.
// Output channel m_*: exactly one result item per input item, giving the pin
// levels, the received 14-bit word on the tick it completes, and idle.
// Path: an input item is taken into the input register, and its result then
// goes into the result register, which drives m_tvalid. Throughput: one item
// per cycle while m_tready does not stall the result register, set by the
// combinational next-state logic between the two registers.
// When m_tready is low the result register holds and the input register
// absorbs one more item; s_tready then drops until the result is taken.
// Reset clears the transfer state: pins low, idle, no item pending.
// ----------------------------------------------------------------------------
module icsp_bit_serial_transfer
	import icsp_pkg::*;
(
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   s_tvalid,
	output logic                  s_tready,
	// [0] dat_in, [1] dir_in, [8:2] bit_len, [16:9] delay_ticks,
	// [17] mclr_level, [81:18] send_bits, [87:82] zero
	input  wire  [IN_DATA_W-1:0]  s_tdata,
	// [0] func
	input  wire                   s_tuser,
	output logic                  m_tvalid,
	input  wire                   m_tready,
	// [0] clk_out, [1] dat_out, [2] dat_drive, [3] mclr_out, [4] word_valid,
	// [18:5] rx_word, [19] idle, [23:20] zero
	output logic [OUT_DATA_W-1:0] m_tdata
);

	in_item_t  item_s1;
	logic      valid_s1;
	state_t    st_q;
	state_t    st_nx;
	out_item_t res;
	out_item_t res_q;
	logic      out_free;
	logic      adv_s1;

	assign out_free = !m_tvalid || m_tready;
	assign adv_s1   = valid_s1 && out_free;
	assign s_tready = !valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.func        <= func_t'(s_tuser);
			item_s1.dat_in      <= s_tdata[0];
			item_s1.dir_in      <= s_tdata[1];
			item_s1.bit_len     <= s_tdata[8:2];
			item_s1.delay_ticks <= s_tdata[16:9];
			item_s1.mclr_level  <= s_tdata[17];
			item_s1.send_bits   <= s_tdata[81:18];
		end
	end

	icsp_step u_step (
		.item  (item_s1),
		.st    (st_q),
		.st_nx (st_nx),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= '0;
			m_tvalid <= 1'b0;
		end else begin
			if (adv_s1)
				st_q <= st_nx;
			if (out_free)
				m_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1)
			res_q <= res;
	end

	assign m_tdata = {{(OUT_DATA_W-20){1'b0}}, res_q.idle, res_q.rx_word,
	                  res_q.word_valid, res_q.mclr_out, res_q.dat_drive,
	                  res_q.dat_out, res_q.clk_out};

	a_word_only_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && res_q.word_valid |-> !res_q.dat_drive)
		else $error("word delivered on a send transfer");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.busy |-> ({1'b0, st_q.bit_count} <=
		               {3'b0, st_q.cur_len} + {2'b0, st_q.cur_delay}))
		else $error("bit count ran past transfer length");

	a_clk_high_mid_bit: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.clk_level |-> st_q.busy && (st_q.bit_count < {2'b0, st_q.cur_len}))
		else $error("serial clock high outside a bit");

	a_read_done_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		!st_q.busy && st_q.cur_dir_in |-> st_q.word_sent)
		else $error("read finished without delivering a word");

endmodule
`default_nettype wire
